>>> design/assert_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SLWG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define SLWG_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed");
`else
`define SLWG_ASSERT(label, prop)
`define SLWG_ASSERT_NEVER(label, expr)
`endif
`endif

>>> design/slwg_pkg.sv
`default_nettype none
package slwg_pkg;
  localparam int MAX_POINTS = 64;
  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int SPC_W = 31;
  localparam int MUL_W = SPC_W + PIDX_W;
  localparam int ROOT_W = 33;
  localparam int REM_W = 37;
  localparam int OPND_W = 66;
  localparam int SQRT_STEPS = OPND_W / 2;
  localparam int DIV_STEPS = 32;
  localparam logic [SPC_W-1:0] SPACING_RESET = 31'd6554;

  typedef enum logic {
    MODE_SQRT,
    MODE_DIV
  } unit_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_SEARCH,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_DIVY_GO,
    ST_DIVY_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              start;
    unit_mode_e        mode;
    logic [PIDX_W-1:0] den;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
    logic [REM_W-1:0]  rem;
  } unit_rsp_t;
endpackage
`default_nettype wire

>>> design/slwg_iter_unit.sv
`default_nettype none
// Shared shift-subtract unit: restoring square root or division, one digit per cycle.
module slwg_iter_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire slwg_pkg::unit_req_t         req_i,
  input  wire logic [slwg_pkg::OPND_W-1:0] opnd_i,
  output slwg_pkg::unit_rsp_t              rsp_o
);
  logic [slwg_pkg::OPND_W-1:0] opnd_q, opnd_d;
  logic [slwg_pkg::REM_W-1:0]  rem_q, rem_d, shifted, trial, diff;
  logic [slwg_pkg::ROOT_W-1:0] res_q, res_d;
  logic [5:0]                  cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d, ge;
  slwg_pkg::unit_mode_e        mode_q, mode_d;
  logic [slwg_pkg::PIDX_W-1:0] den_q, den_d;

  always_comb begin
    if (mode_q == slwg_pkg::MODE_SQRT) begin
      shifted = {rem_q[slwg_pkg::REM_W-3:0], opnd_q[slwg_pkg::OPND_W-1 -: 2]};
      trial   = {2'b00, res_q, 2'b01};
    end else begin
      shifted = {rem_q[slwg_pkg::REM_W-2:0], opnd_q[slwg_pkg::OPND_W-1]};
      trial   = {{(slwg_pkg::REM_W-slwg_pkg::PIDX_W){1'b0}}, den_q};
    end
    ge   = shifted >= trial;
    diff = shifted - trial;
  end

  always_comb begin
    opnd_d = opnd_q;
    rem_d  = rem_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    mode_d = mode_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (req_i.start) begin
      opnd_d = opnd_i;
      rem_d  = '0;
      res_d  = '0;
      mode_d = req_i.mode;
      den_d  = req_i.den;
      busy_d = 1'b1;
      cnt_d  = (req_i.mode == slwg_pkg::MODE_SQRT) ? 6'(slwg_pkg::SQRT_STEPS - 1)
                                                   : 6'(slwg_pkg::DIV_STEPS - 1);
    end else if (busy_q) begin
      rem_d = ge ? diff : shifted;
      res_d = {res_q[slwg_pkg::ROOT_W-2:0], ge};
      if (mode_q == slwg_pkg::MODE_SQRT) begin
        opnd_d = {opnd_q[slwg_pkg::OPND_W-3:0], 2'b00};
      end else begin
        opnd_d = {opnd_q[slwg_pkg::OPND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= slwg_pkg::MODE_SQRT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    den_q  <= den_d;
  end

  assign rsp_o = {done_q, res_q, rem_q};
endmodule
`default_nettype wire

>>> design/straight_line_waypoint_generator.sv
// Straight-line waypoint generator.
// Input channel (in_valid_i/in_ready_o): func_i = 0 is an odometry transaction
// that stores the position, func_i = 1 a goal transaction. A goal plans at once
// if a position is known, else it waits for the next odometry transaction.
// Output channel (out_valid_o/out_ready_i): one transaction per waypoint, from
// start to goal, point_index counting up, last_point set on the final one.
// cfg_we_i/cfg_wdata_i write the point spacing (Q15.16); the user is to write
// it only while idle, which the block itself does not enforce. A plan runs
// the squaring, the square root, the spacing search and the division of x and
// then of y, root and divisions in the shared shift-subtract unit; points then
// leave one per cycle while out_ready_i is high. A transaction that plans
// nothing leaves the block idle. One transaction at a time: in_ready_o is low
// from the plan start until the last point is taken.
// A stall on out_ready_i holds the current point.
// Reset clears the known position and waiting goal and sets spacing to 6554.
`default_nettype none
`include "assert_macros.svh"
module straight_line_waypoint_generator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [slwg_pkg::SPC_W-1:0]     cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           func_i,
  input  wire logic signed [31:0]             pos_x_i,
  input  wire logic signed [31:0]             pos_y_i,
  input  wire logic signed [31:0]             pos_z_i,
  input  wire logic signed [15:0]             quat_x_i,
  input  wire logic signed [15:0]             quat_y_i,
  input  wire logic signed [15:0]             quat_z_i,
  input  wire logic signed [15:0]             quat_w_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [31:0]                  way_x_o,
  output logic signed [31:0]                  way_y_o,
  output logic signed [31:0]                  way_z_o,
  output logic signed [15:0]                  out_qx_o,
  output logic signed [15:0]                  out_qy_o,
  output logic signed [15:0]                  out_qz_o,
  output logic signed [15:0]                  out_qw_o,
  output logic [slwg_pkg::PIDX_W-1:0]         point_index_o,
  output logic                                last_point_o
);
  localparam int PW = slwg_pkg::PIDX_W;

  slwg_pkg::state_e state_q, state_d;
  logic [slwg_pkg::SPC_W-1:0] spacing_q;
  logic have_pos_q, goal_wait_q;
  logic [31:0] cur_x_q, cur_y_q, cur_z_q, goal_x_q, goal_y_q;
  logic [15:0] gq_x_q, gq_y_q, gq_z_q, gq_w_q;
  logic [63:0] prod_q;
  logic [64:0] dsum_q;
  logic [33:0] root_q;
  logic [slwg_pkg::MUL_W-1:0] m_q;
  logic [PW-1:0] k_q, den_q, idx_q;
  logic [31:0] qx_q, qy_q, accx_q, accy_q;
  logic [PW-1:0] rx_q, ry_q;
  logic [PW:0] remx_q, remy_q;
  logic in_acc, out_acc, plan_go, hit;
  logic [32:0] dx, dy;
  logic [31:0] ax, ay, mul_a;
  logic [PW:0] sumx, sumy;
  slwg_pkg::unit_req_t req;
  slwg_pkg::unit_rsp_t rsp;
  logic [slwg_pkg::OPND_W-1:0] opnd;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign plan_go = in_acc && ((!func_i && goal_wait_q) || (func_i && have_pos_q));

  assign dx = {goal_x_q[31], goal_x_q} - {cur_x_q[31], cur_x_q};
  assign dy = {goal_y_q[31], goal_y_q} - {cur_y_q[31], cur_y_q};
  assign ax = dx[32] ? 32'(-dx) : dx[31:0];
  assign ay = dy[32] ? 32'(-dy) : dy[31:0];
  assign mul_a = (state_q == slwg_pkg::ST_SQX) ? ax : ay;
  assign hit = m_q >= {{(slwg_pkg::MUL_W-34){1'b0}}, root_q};
  assign sumx = remx_q + {1'b0, rx_q};
  assign sumy = remy_q + {1'b0, ry_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slwg_pkg::ST_IDLE:      if (plan_go) state_d = slwg_pkg::ST_SQX;
      slwg_pkg::ST_SQX:       state_d = slwg_pkg::ST_SQY;
      slwg_pkg::ST_SQY:       state_d = slwg_pkg::ST_SUM;
      slwg_pkg::ST_SUM:       state_d = slwg_pkg::ST_SQRT_GO;
      slwg_pkg::ST_SQRT_GO:   state_d = slwg_pkg::ST_SQRT_WAIT;
      slwg_pkg::ST_SQRT_WAIT: if (rsp.done) state_d = slwg_pkg::ST_SEARCH;
      slwg_pkg::ST_SEARCH: begin
        if (hit || k_q == PW'(slwg_pkg::MAX_POINTS - 1)) state_d = slwg_pkg::ST_DIVX_GO;
      end
      slwg_pkg::ST_DIVX_GO:   state_d = slwg_pkg::ST_DIVX_WAIT;
      slwg_pkg::ST_DIVX_WAIT: if (rsp.done) state_d = slwg_pkg::ST_DIVY_GO;
      slwg_pkg::ST_DIVY_GO:   state_d = slwg_pkg::ST_DIVY_WAIT;
      slwg_pkg::ST_DIVY_WAIT: if (rsp.done) state_d = slwg_pkg::ST_EMIT;
      slwg_pkg::ST_EMIT:      if (out_acc && idx_q == den_q) state_d = slwg_pkg::ST_IDLE;
      default:                state_d = slwg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == slwg_pkg::ST_IDLE;
    out_valid_o = state_q == slwg_pkg::ST_EMIT;
    req.start   = state_q == slwg_pkg::ST_SQRT_GO || state_q == slwg_pkg::ST_DIVX_GO ||
                  state_q == slwg_pkg::ST_DIVY_GO;
    req.mode    = (state_q == slwg_pkg::ST_SQRT_GO) ? slwg_pkg::MODE_SQRT
                                                    : slwg_pkg::MODE_DIV;
    req.den     = den_q;
    unique case (state_q)
      slwg_pkg::ST_SQRT_GO: opnd = {1'b0, dsum_q};
      slwg_pkg::ST_DIVX_GO: opnd = {ax, 34'd0};
      default:              opnd = {ay, 34'd0};
    endcase
  end

  slwg_iter_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opnd_i (opnd),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slwg_pkg::ST_IDLE;
      spacing_q   <= slwg_pkg::SPACING_RESET;
      have_pos_q  <= 1'b0;
      goal_wait_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_z_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      gq_x_q      <= '0;
      gq_y_q      <= '0;
      gq_z_q      <= '0;
      gq_w_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) spacing_q <= cfg_wdata_i;
      if (in_acc) begin
        if (!func_i) begin
          cur_x_q     <= pos_x_i;
          cur_y_q     <= pos_y_i;
          cur_z_q     <= pos_z_i;
          have_pos_q  <= 1'b1;
          goal_wait_q <= 1'b0;
        end else begin
          goal_x_q    <= pos_x_i;
          goal_y_q    <= pos_y_i;
          gq_x_q      <= quat_x_i;
          gq_y_q      <= quat_y_i;
          gq_z_q      <= quat_z_i;
          gq_w_q      <= quat_w_i;
          goal_wait_q <= !have_pos_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_a;
    unique case (state_q)
      slwg_pkg::ST_SQY: dsum_q <= {1'b0, prod_q};
      slwg_pkg::ST_SUM: dsum_q <= dsum_q + {1'b0, prod_q};
      slwg_pkg::ST_SQRT_WAIT: begin
        root_q <= {1'b0, rsp.result} + {33'd0, (rsp.rem != '0)};
        m_q    <= '0;
        k_q    <= '0;
      end
      slwg_pkg::ST_SEARCH: begin
        if (hit) begin
          den_q <= (k_q == '0) ? PW'(1) : k_q;
        end else if (k_q == PW'(slwg_pkg::MAX_POINTS - 1)) begin
          den_q <= PW'(slwg_pkg::MAX_POINTS - 1);
        end else begin
          k_q <= k_q + PW'(1);
          m_q <= m_q + {{PW{1'b0}}, spacing_q};
        end
      end
      slwg_pkg::ST_DIVX_WAIT: begin
        qx_q <= rsp.result[31:0];
        rx_q <= rsp.rem[PW-1:0];
      end
      slwg_pkg::ST_DIVY_WAIT: begin
        qy_q   <= rsp.result[31:0];
        ry_q   <= rsp.rem[PW-1:0];
        accx_q <= '0;
        accy_q <= '0;
        remx_q <= {2'b00, den_q[PW-1:1]};
        remy_q <= {2'b00, den_q[PW-1:1]};
        idx_q  <= '0;
      end
      slwg_pkg::ST_EMIT: begin
        if (out_acc) begin
          idx_q <= idx_q + PW'(1);
          if (sumx >= {1'b0, den_q}) begin
            remx_q <= sumx - {1'b0, den_q};
            accx_q <= accx_q + qx_q + 32'd1;
          end else begin
            remx_q <= sumx;
            accx_q <= accx_q + qx_q;
          end
          if (sumy >= {1'b0, den_q}) begin
            remy_q <= sumy - {1'b0, den_q};
            accy_q <= accy_q + qy_q + 32'd1;
          end else begin
            remy_q <= sumy;
            accy_q <= accy_q + qy_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign way_x_o       = dx[32] ? cur_x_q - accx_q : cur_x_q + accx_q;
  assign way_y_o       = dy[32] ? cur_y_q - accy_q : cur_y_q + accy_q;
  assign way_z_o       = cur_z_q;
  assign out_qx_o      = gq_x_q;
  assign out_qy_o      = gq_y_q;
  assign out_qz_o      = gq_z_q;
  assign out_qw_o      = gq_w_q;
  assign point_index_o = idx_q;
  assign last_point_o  = idx_q == den_q;

  `SLWG_ASSERT_NEVER(a_no_in_while_out, in_ready_o && out_valid_o)
  `SLWG_ASSERT(a_last_is_goal, out_valid_o && last_point_o |-> way_x_o == goal_x_q && way_y_o == goal_y_q)
  `SLWG_ASSERT(a_first_is_start, out_valid_o && point_index_o == '0 |-> way_x_o == cur_x_q)
  `SLWG_ASSERT(a_plan_leaves_idle, plan_go |=> state_q == slwg_pkg::ST_SQX)
endmodule
`default_nettype wire
